// ===== rtl/topic_filter_match_dispatch_top_macros.svh =====
// Assertion macros for the topic filter match and dispatch block.
// Included by the checker module; needs clk and rst_n in the including scope.
`ifndef TOPIC_FILTER_MATCH_DISPATCH_TOP_MACROS_SVH
`define TOPIC_FILTER_MATCH_DISPATCH_TOP_MACROS_SVH

// Checked only while the block is out of reset.
`define TFMD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define TFMD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tfmd_pkg.sv =====
// Shared constants, types and codes for the topic filter match and dispatch block.
// Used by the slot matcher, the top level and the checker; depends on nothing.
`default_nettype none

package tfmd_pkg;

  localparam int SLOTS      = 4;
  localparam int FILTER_LEN = 64;
  localparam int LEN_W      = $clog2(FILTER_LEN + 1);
  localparam int ADDR_W     = $clog2(FILTER_LEN);
  localparam int MASK_W     = 4;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_TOPIC = 2'd2;

  localparam logic [7:0] CH_SEP  = 8'h2F;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_HASH = 8'h23;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_PLUS   = 4'b0010,
    MODE_HASH   = 4'b0100,
    MODE_FAIL   = 4'b1000
  } mode_t;

  typedef struct packed {
    logic       go;
    logic       load;
    logic       clear;
    logic       topic;
    logic       last;
    logic [7:0] data;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/tfmd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the filter byte store of each slot.
`default_nettype none

module tfmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/tfmd_slot.sv =====
// One subscription slot: filter store, load control and the wildcard matcher.
// Depends on tfmd_pkg and tfmd_ram.
`default_nettype none

module tfmd_slot (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          sel,
  input  wire tfmd_pkg::cmd_t cmd,
  output logic               hit
);

  import tfmd_pkg::*;

  logic              valid_r, valid_nxt;
  logic              ovf_r, ovf_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  mode_t             mode_r, mode_nxt;
  logic              byp_r, byp_nxt;
  logic [7:0]        byp_data_r;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rd_data;
  logic [7:0]        fbyte;

  logic [LEN_W-1:0]  base_len;
  logic              base_ovf;
  logic [LEN_W-1:0]  adv_pos;
  mode_t             adv_mode;
  mode_t             eff_mode;
  logic              try_step;

  // The read port always holds the filter byte at the current match position;
  // a write to that same address is forwarded around the memory.
  tfmd_ram #(
    .WIDTH (8),
    .DEPTH (FILTER_LEN)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (cmd.data),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign fbyte = byp_r ? byp_data_r : rd_data;

  always_comb begin
    adv_pos  = pos_r;
    adv_mode = mode_r;
    eff_mode = mode_r;
    try_step = 1'b0;
    unique case (mode_r) inside
      MODE_NORMAL: begin
        try_step = 1'b1;
      end
      MODE_PLUS: begin
        if (cmd.data == CH_SEP) begin
          try_step = 1'b1;
          eff_mode = MODE_NORMAL;
        end
      end
      MODE_HASH, MODE_FAIL: begin
        try_step = 1'b0;
      end
      default: begin
        try_step = 1'b0;
      end
    endcase
    if (try_step) begin
      if (pos_r >= len_r) begin
        adv_mode = MODE_FAIL;
      end else if (cmd.data == CH_SEP && fbyte != CH_SEP) begin
        adv_mode = MODE_FAIL;
      end else if (fbyte == CH_PLUS) begin
        adv_pos  = pos_r + LEN_W'(1);
        adv_mode = MODE_PLUS;
      end else if (fbyte == CH_HASH) begin
        adv_pos  = pos_r + LEN_W'(1);
        adv_mode = MODE_HASH;
      end else if (fbyte != cmd.data) begin
        adv_mode = MODE_FAIL;
      end else begin
        adv_pos  = pos_r + LEN_W'(1);
        adv_mode = eff_mode;
      end
    end
  end

  assign hit = valid_r && (adv_mode != MODE_FAIL) && (adv_pos == len_r);

  assign base_len = valid_r ? '0 : len_r;
  assign base_ovf = valid_r ? 1'b0 : ovf_r;
  assign waddr    = base_len[ADDR_W-1:0];

  always_comb begin
    valid_nxt = valid_r;
    ovf_nxt   = ovf_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    mode_nxt  = mode_r;
    we        = 1'b0;
    if (cmd.go && sel && cmd.load) begin
      pos_nxt   = '0;
      mode_nxt  = MODE_NORMAL;
      valid_nxt = 1'b0;
      len_nxt   = base_len;
      ovf_nxt   = base_ovf;
      if (base_len < LEN_W'(FILTER_LEN)) begin
        we      = 1'b1;
        len_nxt = base_len + LEN_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
      if (cmd.last) begin
        if (ovf_nxt) begin
          len_nxt = '0;
          ovf_nxt = 1'b0;
        end else begin
          valid_nxt = 1'b1;
        end
      end
    end else if (cmd.go && sel && cmd.clear) begin
      valid_nxt = 1'b0;
      ovf_nxt   = 1'b0;
      len_nxt   = '0;
      pos_nxt   = '0;
      mode_nxt  = MODE_NORMAL;
    end else if (cmd.go && cmd.topic) begin
      if (cmd.last) begin
        pos_nxt  = '0;
        mode_nxt = MODE_NORMAL;
      end else begin
        pos_nxt  = adv_pos;
        mode_nxt = adv_mode;
      end
    end
  end

  assign raddr   = pos_nxt[ADDR_W-1:0];
  assign byp_nxt = we && (waddr == raddr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ovf_r   <= 1'b0;
      len_r   <= '0;
      pos_r   <= '0;
      mode_r  <= MODE_NORMAL;
      byp_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      ovf_r   <= ovf_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      mode_r  <= mode_nxt;
      byp_r   <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= cmd.data;
  end

endmodule

`default_nettype wire

// ===== rtl/topic_filter_match_dispatch_top.sv =====
// A topic word with last set is held in the input register; its result is registered into
// the output register when the word goes. Throughput: one word per cycle while the output
// is not stalled; filter reads are prefetched for the next match position of each slot.
// Reset (rst_n low, synchronous) empties both registers, invalidates all slots and
// clears default_enable; filter memory contents are not cleared and unwritten bytes are never used.
// Top level of the topic filter match and dispatch block; uses tfmd_pkg and tfmd_slot.
`default_nettype none

module topic_filter_match_dispatch_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_opcode,
  input  wire logic [1:0]                  in_slot,
  input  wire logic [7:0]                  in_data_byte,
  input  wire logic                        in_last,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [tfmd_pkg::MASK_W-1:0]      out_match_mask,
  output logic                             out_default_taken,
  output logic                             out_delivered
);

  import tfmd_pkg::*;

  logic              dflt_en_r;
  logic              in_valid_r;
  logic [1:0]        opcode_r;
  logic [1:0]        slot_r;
  logic [7:0]        data_r;
  logic              last_r;

  logic              out_valid_r;
  logic [MASK_W-1:0] mask_r;
  logic              dflt_r;
  logic              dlvd_r;

  logic              gives_result;
  logic              go;
  logic              in_take;
  cmd_t              cmd;
  logic [SLOTS-1:0]  hit;
  logic [SLOTS-1:0]  sel;
  logic [MASK_W-1:0] mask;
  logic              dflt;

  assign gives_result = (opcode_r == OP_TOPIC) && last_r;
  assign go           = in_valid_r && (!gives_result || !out_valid_r || !out_stall);
  assign in_stall     = in_valid_r && !go;
  assign in_take      = in_valid && !in_stall;

  always_comb begin
    cmd.go    = go;
    cmd.load  = (opcode_r == OP_LOAD);
    cmd.clear = (opcode_r == OP_CLEAR);
    cmd.topic = (opcode_r == OP_TOPIC);
    cmd.last  = last_r;
    cmd.data  = data_r;
  end

  for (genvar k = 0; k < SLOTS; k++) begin : g_slot
    assign sel[k] = (32'(slot_r) == k);
    tfmd_slot u_slot (
      .clk   (clk),
      .rst_n (rst_n),
      .sel   (sel[k]),
      .cmd   (cmd),
      .hit   (hit[k])
    );
  end

  always_comb begin
    mask = '0;
    for (int k = 0; k < MASK_W && k < SLOTS; k++) begin
      mask[k] = hit[k];
    end
  end

  assign dflt = (mask == '0) && dflt_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_en_r   <= 1'b0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        dflt_en_r <= cfg_wdata;
      end
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (go) begin
        in_valid_r <= 1'b0;
      end
      if (go && gives_result) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      opcode_r <= in_opcode;
      slot_r   <= in_slot;
      data_r   <= in_data_byte;
      last_r   <= in_last;
    end
    if (go && gives_result) begin
      mask_r <= mask;
      dflt_r <= dflt;
      dlvd_r <= (mask != '0) || dflt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_match_mask    = mask_r;
  assign out_default_taken = dflt_r;
  assign out_delivered     = dlvd_r;

endmodule

`default_nettype wire

// ===== rtl/tfmd_checker.sv =====
// Port-level checker for the topic filter match and dispatch top level, with its bind.
// Depends on tfmd_pkg and the assertion macros header.
`default_nettype none

`include "topic_filter_match_dispatch_top_macros.svh"

module tfmd_checker (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic [1:0]             in_opcode,
  input wire logic [1:0]             in_slot,
  input wire logic [7:0]             in_data_byte,
  input wire logic                   in_last,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic [tfmd_pkg::MASK_W-1:0] out_match_mask,
  input wire logic                   out_default_taken,
  input wire logic                   out_delivered
);

  `TFMD_ASSERT_ALWAYS(a_empty_after_reset, !rst_n |=> !out_valid,
    "result word present after reset")
  `TFMD_ASSERT(a_delivered,
    out_valid |-> (out_delivered == ((out_match_mask != '0) || out_default_taken)),
    "delivered flag inconsistent with mask and default")
  `TFMD_ASSERT(a_default_alone,
    (out_valid && out_default_taken) |-> (out_match_mask == '0),
    "default taken although a slot matched")
  `TFMD_ASSERT(a_out_hold,
    (out_valid && out_stall) |=> (out_valid && $stable(out_match_mask)),
    "stalled result word dropped or changed")
  `TFMD_ASSERT(a_in_hold,
    (in_valid && in_stall) |=>
      (in_valid && $stable({in_opcode, in_slot, in_data_byte, in_last})),
    "stalled input word dropped or changed")

endmodule

bind topic_filter_match_dispatch_top tfmd_checker u_tfmd_checker (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for topic_filter_match_dispatch_top: filter loads, clears and
// topic words are checked against a built-in model of the wildcard matcher.
// Depends on tfmd_pkg and the top level only.

module tb_top;
  import tfmd_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RAND_WORDS = 1380;
  localparam int PHASES = 6;
  localparam int SCRATCH_DEPTH = 256;
  localparam int KNOWN_DEPTH = 72;
  localparam int REPORT_CAP = 60;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] slot;
    logic [7:0] data;
    logic       last;
  } word_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              dflt;
    logic              delivered;
  } dispatch_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic [1:0] in_slot = '0;
  logic [7:0] in_data_byte = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [MASK_W-1:0] out_match_mask;
  logic out_default_taken;
  logic out_delivered;

  topic_filter_match_dispatch_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_slot           (in_slot),
    .in_data_byte      (in_data_byte),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_match_mask    (out_match_mask),
    .out_default_taken (out_default_taken),
    .out_delivered     (out_delivered)
  );

  always #2 clk = ~clk;

  word_t     pending_words[$];
  dispatch_t expected_dispatch[$];
  int        mismatch_count = 0;
  int        words_queued = 0;
  int        src_idle_pct = 0;
  int        snk_idle_pct = 0;
  bit        hold_req = 1'b0;

  // Model of the matcher state.
  logic [7:0]  slot_filter[SLOTS][FILTER_LEN];
  int unsigned slot_len[SLOTS];
  int unsigned slot_pos[SLOTS];
  bit          slot_live[SLOTS];
  bit          slot_ovf[SLOTS];
  mode_t       slot_mode[SLOTS];
  bit          fallback_en = 1'b0;

  // What the stimulus side believes each slot holds.
  logic [7:0] known_bytes[SLOTS][KNOWN_DEPTH];
  int         known_len[SLOTS];
  bit         known_live[SLOTS];
  bit         known_dirty[SLOTS];
  logic [7:0] scratch_bytes[SCRATCH_DEPTH];
  int         scratch_len;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  function automatic void advance_slot(input int s, input logic [7:0] b);
    mode_t m;
    logic [7:0] f;
    m = slot_mode[s];
    if (m == MODE_FAIL || m == MODE_HASH) return;
    if (m == MODE_PLUS) begin
      if (b != CH_SEP) return;
      m = MODE_NORMAL;
    end
    if (slot_pos[s] >= slot_len[s] || slot_pos[s] >= FILTER_LEN) begin
      slot_mode[s] = MODE_FAIL;
      return;
    end
    f = slot_filter[s][slot_pos[s]];
    if (b == CH_SEP && f != CH_SEP) begin
      slot_mode[s] = MODE_FAIL;
      return;
    end
    if (f == CH_PLUS) m = MODE_PLUS;
    else if (f == CH_HASH) m = MODE_HASH;
    else if (f != b) begin
      slot_mode[s] = MODE_FAIL;
      return;
    end
    slot_pos[s]++;
    slot_mode[s] = m;
  endfunction

  function automatic void route_word(input logic [1:0] op, input logic [1:0] slot,
                                     input logic [7:0] data, input logic last);
    int s;
    dispatch_t d;
    s = slot;
    if (op == OP_LOAD || op == OP_CLEAR) begin
      if (s >= SLOTS) return;
      slot_pos[s] = 0;
      slot_mode[s] = MODE_NORMAL;
      if (op == OP_CLEAR || slot_live[s]) begin
        slot_live[s] = 1'b0;
        slot_len[s] = 0;
        slot_ovf[s] = 1'b0;
      end
      if (op == OP_CLEAR) return;
      if (slot_len[s] < FILTER_LEN) begin
        slot_filter[s][slot_len[s]] = data;
        slot_len[s]++;
      end else begin
        slot_ovf[s] = 1'b1;
      end
      if (last) begin
        if (slot_ovf[s]) begin
          slot_len[s] = 0;
          slot_ovf[s] = 1'b0;
        end else begin
          slot_live[s] = 1'b1;
        end
      end
      return;
    end
    if (op != OP_TOPIC) return;
    for (int k = 0; k < SLOTS; k++) advance_slot(k, data);
    if (!last) return;
    d = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (slot_live[k] && slot_mode[k] != MODE_FAIL && slot_pos[k] == slot_len[k])
        d.mask[k] = 1'b1;
      slot_pos[k] = 0;
      slot_mode[k] = MODE_NORMAL;
    end
    d.dflt = (d.mask == '0) && fallback_en;
    d.delivered = (d.mask != '0) || d.dflt;
    expected_dispatch.push_back(d);
  endfunction

  function automatic int idle_span();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Driver.
  int src_gap = 0;
  always @(posedge clk) begin
    word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_valid && !in_stall) route_word(in_opcode, in_slot, in_data_byte, in_last);
      if (!in_valid || !in_stall) begin
        if (src_gap == 0 && src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct)
          src_gap = idle_span();
        if (src_gap != 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          in_opcode <= w.op;
          in_slot <= w.slot;
          in_data_byte <= w.data;
          in_last <= w.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall control.
  int snk_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      snk_left = 0;
    end else begin
      if (snk_left == 0) begin
        if (hold_req) begin
          snk_left = HOLD_CYCLES;
          hold_req = 1'b0;
        end else if (snk_idle_pct > 0 && $urandom_range(0, 99) < snk_idle_pct) begin
          snk_left = idle_span();
        end
      end
      if (snk_left != 0) begin
        snk_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    dispatch_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_dispatch.size() == 0) begin
        report_mismatch($sformatf("unexpected result mask %h", out_match_mask));
      end else begin
        e = expected_dispatch.pop_front();
        if (out_match_mask !== e.mask)
          report_mismatch($sformatf("match_mask %h, expected %h", out_match_mask, e.mask));
        if (out_default_taken !== e.dflt)
          report_mismatch($sformatf("default_taken %b, expected %b", out_default_taken,
                                    e.dflt));
        if (out_delivered !== e.delivered)
          report_mismatch($sformatf("delivered %b, expected %b", out_delivered,
                                    e.delivered));
      end
    end
  end

  // Watchdog.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic push_word(input logic [1:0] op, input logic [1:0] slot,
                           input logic [7:0] data, input logic last);
    word_t w;
    w.op = op;
    w.slot = slot;
    w.data = data;
    w.last = last;
    pending_words.push_back(w);
    words_queued++;
  endtask

  function automatic logic [7:0] name_byte(input bit allow_sep);
    case ($urandom_range(0, allow_sep ? 5 : 4))
      0: return 8'h61;
      1: return 8'h62;
      2: return 8'h00;
      3: return 8'hFF;
      4: return 8'(($urandom_range(0, 255) == CH_SEP) ? 8'h63 : $urandom_range(0, 255));
      default: return CH_SEP;
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] b);
    if (scratch_len < SCRATCH_DEPTH) begin
      scratch_bytes[scratch_len] = b;
      scratch_len++;
    end
  endtask

  task automatic forget_slot(input int s);
    known_len[s] = 0;
    known_live[s] = 1'b0;
    known_dirty[s] = 1'b0;
  endtask

  task automatic build_filter();
    int levels, r, n;
    scratch_len = 0;
    levels = $urandom_range(1, 4);
    for (int lev = 0; lev < levels; lev++) begin
      if (lev > 0) add_byte(CH_SEP);
      r = $urandom_range(0, 99);
      if (r < 15) begin
        add_byte(CH_PLUS);
      end else if (r < 25) begin
        add_byte(CH_HASH);
        break;
      end else begin
        n = $urandom_range(0, 3);
        repeat (n) add_byte(name_byte(1'b0));
      end
    end
    if (scratch_len == 0) add_byte(name_byte(1'b0));
  endtask

  task automatic load_scratch(input int s);
    if (known_dirty[s]) push_word(OP_CLEAR, 2'(s), 8'(s), 1'b0);
    for (int i = 0; i < scratch_len; i++) begin
      push_word(OP_LOAD, 2'(s), scratch_bytes[i], i == scratch_len - 1);
      if (i < KNOWN_DEPTH) known_bytes[s][i] = scratch_bytes[i];
    end
    known_live[s] = scratch_len <= FILTER_LEN;
    known_len[s] = known_live[s] ? scratch_len : 0;
    known_dirty[s] = 1'b0;
  endtask

  task automatic random_topic();
    int n;
    scratch_len = 0;
    n = $urandom_range(1, 6);
    repeat (n) add_byte(name_byte(1'b1));
  endtask

  task automatic send_topic(input bit interrupt);
    int cut, t;
    cut = interrupt ? $urandom_range(0, scratch_len - 1) : -1;
    for (int i = 0; i < scratch_len; i++) begin
      if (i == cut) begin
        t = $urandom_range(0, SLOTS - 1);
        push_word(OP_CLEAR, 2'(t), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        forget_slot(t);
        if ($urandom_range(0, 1)) begin
          known_bytes[t][0] = name_byte(1'b0);
          push_word(OP_LOAD, 2'(t), known_bytes[t][0], 1'b1);
          known_len[t] = 1;
          known_live[t] = 1'b1;
        end
      end
      push_word(OP_TOPIC, 2'($urandom_range(0, 3)), scratch_bytes[i], i == scratch_len - 1);
    end
  endtask

  task automatic topic_for_slot(input int s, input bit interrupt);
    logic [7:0] f;
    int n, r;
    if (!known_live[s]) begin
      random_topic();
    end else begin
      scratch_len = 0;
      for (int i = 0; i < known_len[s]; i++) begin
        f = known_bytes[s][i];
        if (f == CH_PLUS) begin
          n = $urandom_range(1, 3);
          repeat (n) add_byte(name_byte(1'b0));
        end else if (f == CH_HASH) begin
          add_byte(name_byte(1'b0));
          n = $urandom_range(0, 3);
          repeat (n) add_byte(name_byte(1'b1));
          break;
        end else begin
          add_byte(f);
        end
      end
      r = $urandom_range(0, 99);
      if (r < 15) scratch_bytes[$urandom_range(0, scratch_len - 1)] = name_byte(1'b1);
      else if (r < 22) add_byte(name_byte(1'b1));
      else if (r < 28 && scratch_len > 1) scratch_len--;
    end
    send_topic(interrupt);
  endtask

  task automatic random_episode();
    int r, s, n;
    logic [1:0] op;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, SLOTS - 1);
    if (r < 32) begin
      if (!known_live[s]) begin
        build_filter();
        load_scratch(s);
      end
      topic_for_slot(s, 1'b0);
    end else if (r < 45) begin
      random_topic();
      send_topic(1'b0);
    end else if (r < 62) begin
      build_filter();
      load_scratch(s);
    end else if (r < 70) begin
      topic_for_slot(s, 1'b1);
    end else if (r < 75) begin
      push_word(OP_CLEAR, 2'(s), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      forget_slot(s);
    end else if (r < 78) begin
      case ($urandom_range(0, 3))
        0: scratch_len = FILTER_LEN - 1;
        1: scratch_len = FILTER_LEN;
        2: scratch_len = FILTER_LEN + 1;
        default: scratch_len = $urandom_range(FILTER_LEN - 4, FILTER_LEN + 6);
      endcase
      for (int i = 0; i < scratch_len; i++) scratch_bytes[i] = 8'($urandom_range(0, 255));
      load_scratch(s);
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        op = 2'($urandom_range(0, 3));
        s = $urandom_range(0, SLOTS - 1);
        push_word(op, 2'(s), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        if (op == OP_CLEAR) begin
          forget_slot(s);
        end else if (op == OP_LOAD) begin
          known_live[s] = 1'b0;
          known_dirty[s] = 1'b1;
        end
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_dispatch.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_fallback(input bit v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    fallback_en = v;
  endtask

  initial begin
    int src_pct[PHASES] = '{20, 0, 50, 0, 10, 30};
    int snk_pct[PHASES] = '{20, 0, 10, 0, 50, 30};
    int phase_end;
    for (int s = 0; s < SLOTS; s++) begin
      slot_len[s] = 0;
      slot_pos[s] = 0;
      slot_live[s] = 1'b0;
      slot_ovf[s] = 1'b0;
      slot_mode[s] = MODE_NORMAL;
      forget_slot(s);
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    src_idle_pct = 20;
    snk_idle_pct = 20;
    push_word(OP_TOPIC, 2'd0, 8'h61, 1'b1);
    push_word(OP_LOAD, 2'd0, 8'h61, 1'b0);
    push_word(OP_LOAD, 2'd0, CH_SEP, 1'b0);
    push_word(OP_LOAD, 2'd0, CH_PLUS, 1'b1);
    push_word(OP_LOAD, 2'd1, CH_HASH, 1'b1);
    push_word(OP_TOPIC, 2'd3, 8'h61, 1'b0);
    push_word(OP_TOPIC, 2'd3, CH_SEP, 1'b0);
    push_word(OP_TOPIC, 2'd3, 8'h62, 1'b1);
    push_word(OP_LOAD, 2'd2, 8'h00, 1'b1);
    push_word(OP_TOPIC, 2'd1, 8'h00, 1'b1);
    push_word(OP_SPARE, 2'd3, 8'hFF, 1'b1);
    push_word(OP_LOAD, 2'd0, 8'h78, 1'b1);
    push_word(OP_TOPIC, 2'd2, 8'h78, 1'b0);
    push_word(OP_LOAD, 2'd3, 8'hFF, 1'b1);
    push_word(OP_TOPIC, 2'd0, 8'hFF, 1'b1);
    push_word(OP_CLEAR, 2'd1, 8'hFF, 1'b1);
    push_word(OP_TOPIC, 2'd0, CH_SEP, 1'b1);
    push_word(OP_TOPIC, 2'd2, 8'h61, 1'b1);
    for (int s = 0; s < SLOTS; s++) known_dirty[s] = 1'b1;
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0 || p == 4) write_fallback(1'b1);
      if (p == 2) write_fallback(1'b0);
      src_idle_pct = src_pct[p];
      snk_idle_pct = snk_pct[p];
      if (p == 3) begin
        hold_req = 1'b1;
        while (hold_req) @(posedge clk);
        repeat (100) push_word(OP_TOPIC, 2'($urandom_range(0, 3)), name_byte(1'b1), 1'b1);
      end
      phase_end = words_queued + RAND_WORDS / PHASES;
      while (words_queued < phase_end) random_episode();
      wait_drained();
    end

    if (expected_dispatch.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_dispatch.size()));
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tfmd_pkg.sv
rtl/tfmd_ram.sv
rtl/tfmd_slot.sv
rtl/topic_filter_match_dispatch_top.sv
rtl/tfmd_checker.sv
test/tb_top.sv
